// ===== rtl/pip_pkg.sv =====
package pip_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int COORD_BITS = 31;
  localparam int ADDR_BITS = $clog2(MAX_VERTICES);
  localparam int CNT_BITS = $clog2(MAX_VERTICES + 1);
  localparam int INDEX_BITS = 10;
  localparam int VCOUNT_BITS = 11;
  localparam int LOC_BITS = 2;
  localparam int DATA_BITS = 32;
  localparam int PADDR_BITS = 3;

  // wide enough for the ray end and for every difference of two points
  localparam int PT_BITS = 33;
  localparam int PROD_BITS = 2 * PT_BITS;
  localparam int NCELL = 6;

  localparam logic [PADDR_BITS-3:0] REG_VERTEX_COUNT = '0;
  localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET = VCOUNT_BITS'(3);

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [LOC_BITS-1:0] LOC_INSIDE = 2'd0;
  localparam logic [LOC_BITS-1:0] LOC_OUTSIDE = 2'd1;
  localparam logic [LOC_BITS-1:0] LOC_BOUNDARY = 2'd2;

  typedef logic [1:0] sgn_t;
  localparam sgn_t SGN_ZERO = 2'b00;
  localparam sgn_t SGN_POS = 2'b01;
  localparam sgn_t SGN_NEG = 2'b10;

  typedef logic signed [PT_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  localparam coord_t RAY_Y_END = PT_BITS'(64'sd3000000000);

  typedef enum logic [1:0] {PT_Q, PT_R, PT_A, PT_B} pt_sel_t;

  // cross sign of (p1 - p0) and (p3 - p2)
  typedef struct packed {
    pt_sel_t p0;
    pt_sel_t p1;
    pt_sel_t p2;
    pt_sel_t p3;
  } cell_op_t;

  localparam cell_op_t CELL_OPS [NCELL] = '{
    '{PT_Q, PT_A, PT_Q, PT_B},
    '{PT_Q, PT_R, PT_Q, PT_A},
    '{PT_Q, PT_R, PT_Q, PT_B},
    '{PT_A, PT_B, PT_A, PT_Q},
    '{PT_A, PT_B, PT_A, PT_R},
    '{PT_Q, PT_R, PT_A, PT_B}
  };

  // sign slots after the last cell: the first cell ends up highest
  localparam int SL_ON = NCELL - 1;
  localparam int SL_S1 = NCELL - 2;
  localparam int SL_S2 = NCELL - 3;
  localparam int SL_S3 = NCELL - 4;
  localparam int SL_S4 = NCELL - 5;
  localparam int SL_PAR = NCELL - 6;

  typedef struct packed {
    point_t a;
    point_t b;
    sgn_t [NCELL-1:0] signs;
  } edge_rec_t;

  typedef enum logic [1:0] {W_IDLE, W_READ, W_DRAIN, W_DONE} walk_state_t;

  typedef struct packed {
    logic start;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [CNT_BITS-1:0] n;
  } query_t;

  typedef struct packed {
    logic busy;
    logic res_valid;
    logic [LOC_BITS-1:0] loc;
  } walk_stat_t;

  function automatic point_t to_pt(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y);
    point_t p;
    p.x = PT_BITS'(signed'(x));
    p.y = PT_BITS'(signed'(y));
    return p;
  endfunction

  function automatic point_t pick_pt(pt_sel_t s, point_t q, point_t r, point_t a,
                                     point_t b);
    point_t p;
    case (s)
      PT_Q: p = q;
      PT_R: p = r;
      PT_A: p = a;
      PT_B: p = b;
      default: p = q;
    endcase
    return p;
  endfunction

  function automatic coord_t cmax(coord_t a, coord_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic coord_t cmin(coord_t a, coord_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

// ===== rtl/pip_ram.sv =====
module pip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pip_cell.sv =====
module pip_cell (
  input  logic                clk,
  input  logic                rst,
  input  pip_pkg::cell_op_t   op,
  input  pip_pkg::point_t     q,
  input  pip_pkg::point_t     r,
  input  logic                vld_in,
  input  pip_pkg::edge_rec_t  rec_in,
  output logic                vld_out,
  output pip_pkg::edge_rec_t  rec_out
);

  pip_pkg::point_t p0, p1, p2, p3;
  pip_pkg::coord_t ux, uy, vx, vy;
  logic signed [pip_pkg::PROD_BITS-1:0] lp, rp;
  pip_pkg::edge_rec_t rec1, rec2, rec_next;
  logic vld1, vld2;
  pip_pkg::sgn_t sgn;

  always_comb begin
    p0 = pip_pkg::pick_pt(op.p0, q, r, rec_in.a, rec_in.b);
    p1 = pip_pkg::pick_pt(op.p1, q, r, rec_in.a, rec_in.b);
    p2 = pip_pkg::pick_pt(op.p2, q, r, rec_in.a, rec_in.b);
    p3 = pip_pkg::pick_pt(op.p3, q, r, rec_in.a, rec_in.b);
  end

  always_comb begin
    if (lp > rp) begin
      sgn = pip_pkg::SGN_POS;
    end else if (lp < rp) begin
      sgn = pip_pkg::SGN_NEG;
    end else begin
      sgn = pip_pkg::SGN_ZERO;
    end
    rec_next = rec2;
    rec_next.signs = {rec2.signs[pip_pkg::NCELL-2:0], sgn};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld_out <= 1'b0;
    end else begin
      vld1 <= vld_in;
      vld2 <= vld1;
      vld_out <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    ux <= p1.x - p0.x;
    uy <= p1.y - p0.y;
    vx <= p3.x - p2.x;
    vy <= p3.y - p2.y;
    rec1 <= rec_in;
    lp <= ux * vy;
    rp <= uy * vx;
    rec2 <= rec1;
    rec_out <= rec_next;
  end

endmodule

// ===== rtl/pip_walk.sv =====
module pip_walk (
  input  logic                                  clk,
  input  logic                                  rst,
  input  pip_pkg::query_t                       qry,
  input  logic                                  res_take,
  output pip_pkg::walk_stat_t                   stat,
  output logic [pip_pkg::ADDR_BITS-1:0]         rd_addr,
  input  logic [2*pip_pkg::COORD_BITS-1:0]      rd_data
);

  pip_pkg::walk_state_t state, state_next;
  logic [pip_pkg::CNT_BITS-1:0] n, k, out_cnt;
  logic rd_issue, rd_vld_d, rd_first_d;
  pip_pkg::point_t prev, cur, q_pt, r_pt, fa, fb;
  logic [pip_pkg::NCELL:0] chain_vld;
  pip_pkg::edge_rec_t chain_rec [pip_pkg::NCELL+1];
  pip_pkg::edge_rec_t fo;
  pip_pkg::sgn_t s_on, s1, s2, s3, s4, s_par;
  logic box_out, apart_qr, apart_ab, bnd, crs;
  logic e1_vld, e1_bnd, e1_crs;
  logic hit_bnd, par;

  always_comb begin
    state_next = state;
    case (state)
      pip_pkg::W_IDLE: begin
        if (qry.start) begin
          state_next = (qry.n == '0) ? pip_pkg::W_DONE : pip_pkg::W_READ;
        end
      end
      pip_pkg::W_READ: begin
        if (k == n) begin
          state_next = pip_pkg::W_DRAIN;
        end
      end
      pip_pkg::W_DRAIN: begin
        if (out_cnt == n) begin
          state_next = pip_pkg::W_DONE;
        end
      end
      pip_pkg::W_DONE: begin
        if (res_take) begin
          state_next = pip_pkg::W_IDLE;
        end
      end
      default: state_next = pip_pkg::W_IDLE;
    endcase
  end

  always_comb begin
    rd_issue = (state == pip_pkg::W_READ);
    stat.busy = (state != pip_pkg::W_IDLE);
    stat.res_valid = (state == pip_pkg::W_DONE);
    if (hit_bnd) begin
      stat.loc = pip_pkg::LOC_BOUNDARY;
    end else if (par) begin
      stat.loc = pip_pkg::LOC_INSIDE;
    end else begin
      stat.loc = pip_pkg::LOC_OUTSIDE;
    end
    rd_addr = (k == n) ? '0 : k[pip_pkg::ADDR_BITS-1:0];
  end

  assign cur = pip_pkg::to_pt(rd_data[2*pip_pkg::COORD_BITS-1:pip_pkg::COORD_BITS],
                              rd_data[pip_pkg::COORD_BITS-1:0]);

  always_comb begin
    chain_vld[0] = rd_vld_d & ~rd_first_d;
    chain_rec[0].a = prev;
    chain_rec[0].b = cur;
    chain_rec[0].signs = '0;
  end

  for (genvar c = 0; c < pip_pkg::NCELL; c++) begin : g_chain
    pip_cell u_xc (
      .clk     (clk),
      .rst     (rst),
      .op      (pip_pkg::CELL_OPS[c]),
      .q       (q_pt),
      .r       (r_pt),
      .vld_in  (chain_vld[c]),
      .rec_in  (chain_rec[c]),
      .vld_out (chain_vld[c+1]),
      .rec_out (chain_rec[c+1])
    );
  end

  always_comb begin
    fo = chain_rec[pip_pkg::NCELL];
    fa = fo.a;
    fb = fo.b;
    s_on = fo.signs[pip_pkg::SL_ON];
    s1 = fo.signs[pip_pkg::SL_S1];
    s2 = fo.signs[pip_pkg::SL_S2];
    s3 = fo.signs[pip_pkg::SL_S3];
    s4 = fo.signs[pip_pkg::SL_S4];
    s_par = fo.signs[pip_pkg::SL_PAR];
    box_out = (pip_pkg::cmax(fa.x, fb.x) < q_pt.x) || (pip_pkg::cmax(fa.y, fb.y) < q_pt.y) ||
              (pip_pkg::cmin(fa.x, fb.x) > q_pt.x) || (pip_pkg::cmin(fa.y, fb.y) > q_pt.y);
    apart_qr = (pip_pkg::cmax(q_pt.x, r_pt.x) < pip_pkg::cmin(fa.x, fb.x)) ||
               (pip_pkg::cmax(q_pt.y, r_pt.y) < pip_pkg::cmin(fa.y, fb.y));
    apart_ab = (pip_pkg::cmax(fa.x, fb.x) < pip_pkg::cmin(q_pt.x, r_pt.x)) ||
               (pip_pkg::cmax(fa.y, fb.y) < pip_pkg::cmin(q_pt.y, r_pt.y));
    bnd = (s_on == pip_pkg::SGN_ZERO) && !box_out;
    crs = !((s1 != pip_pkg::SGN_ZERO) && (s1 == s2)) &&
          !((s3 != pip_pkg::SGN_ZERO) && (s3 == s4)) &&
          !((s_par == pip_pkg::SGN_ZERO) && (apart_qr || apart_ab));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pip_pkg::W_IDLE;
      k <= '0;
      rd_vld_d <= 1'b0;
      rd_first_d <= 1'b0;
      e1_vld <= 1'b0;
      hit_bnd <= 1'b0;
      par <= 1'b0;
      out_cnt <= '0;
    end else begin
      state <= state_next;
      rd_vld_d <= rd_issue;
      rd_first_d <= rd_issue && (k == '0);
      e1_vld <= chain_vld[pip_pkg::NCELL];
      if (state == pip_pkg::W_IDLE && qry.start) begin
        k <= '0;
        hit_bnd <= 1'b0;
        par <= 1'b0;
        out_cnt <= '0;
      end else begin
        if (rd_issue) begin
          k <= k + 1'b1;
        end
        if (e1_vld) begin
          hit_bnd <= hit_bnd | e1_bnd;
          par <= par ^ e1_crs;
          out_cnt <= out_cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == pip_pkg::W_IDLE && qry.start) begin
      n <= qry.n;
      q_pt <= pip_pkg::to_pt(qry.x, qry.y);
      r_pt.x <= pip_pkg::PT_BITS'(signed'(qry.x)) + pip_pkg::PT_BITS'(1);
      r_pt.y <= pip_pkg::RAY_Y_END;
    end
    if (rd_vld_d) begin
      prev <= cur;
    end
    e1_bnd <= bnd;
    e1_crs <= crs;
  end

endmodule

// ===== rtl/point_in_polygon_classifier.sv =====
// Ray-casting point-in-polygon classifier. A load item (func 0) writes one vertex into the
// vertex memory and gives no result. A query item (func 1) walks every edge of the polygon
// formed by the first vertex_count vertices (at most 1024) and returns one location: inside,
// outside or on the boundary. The single read port of the vertex memory feeds one edge per
// cycle into a row of six cross-product cells. The next item is taken once the walk is over
// and its result has moved into the output register, where it may still wait. Vertex slots
// must be loaded before a query reads them; the memory is not cleared at reset. Write
// vertex_count only while idle.
module point_in_polygon_classifier (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  func,
  input  logic [pip_pkg::INDEX_BITS-1:0]        vertex_index,
  input  logic signed [pip_pkg::COORD_BITS-1:0] coord_x,
  input  logic signed [pip_pkg::COORD_BITS-1:0] coord_y,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [pip_pkg::LOC_BITS-1:0]          location,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [pip_pkg::PADDR_BITS-1:0]        paddr,
  input  logic [pip_pkg::DATA_BITS-1:0]         pwdata,
  output logic [pip_pkg::DATA_BITS-1:0]         prdata,
  output logic                                  pready
);

  logic [pip_pkg::VCOUNT_BITS-1:0] vertex_count;
  logic accept, cfg_wr, vtx_we, res_take;
  logic [pip_pkg::ADDR_BITS-1:0] rd_addr;
  logic [2*pip_pkg::COORD_BITS-1:0] rd_data;
  pip_pkg::query_t qry;
  pip_pkg::walk_stat_t stat;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    prdata = '0;
    if (paddr[pip_pkg::PADDR_BITS-1:2] == pip_pkg::REG_VERTEX_COUNT) begin
      prdata = pip_pkg::DATA_BITS'(vertex_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= pip_pkg::VCOUNT_RESET;
    end else if (cfg_wr && paddr[pip_pkg::PADDR_BITS-1:2] == pip_pkg::REG_VERTEX_COUNT) begin
      vertex_count <= pwdata[pip_pkg::VCOUNT_BITS-1:0];
    end
  end

  assign in_stall = stat.busy;
  assign accept = in_valid & ~in_stall;
  assign vtx_we = accept && (func == pip_pkg::FUNC_LOAD) &&
                  (32'(vertex_index) < 32'(pip_pkg::MAX_VERTICES));

  always_comb begin
    qry.start = accept && (func == pip_pkg::FUNC_QUERY);
    qry.x = coord_x;
    qry.y = coord_y;
    if (32'(vertex_count) > 32'(pip_pkg::MAX_VERTICES)) begin
      qry.n = pip_pkg::CNT_BITS'(pip_pkg::MAX_VERTICES);
    end else begin
      qry.n = pip_pkg::CNT_BITS'(vertex_count);
    end
  end

  pip_ram #(
    .WIDTH (2 * pip_pkg::COORD_BITS),
    .DEPTH (pip_pkg::MAX_VERTICES)
  ) u_vtx_ram (
    .clk   (clk),
    .we    (vtx_we),
    .waddr (pip_pkg::ADDR_BITS'(vertex_index)),
    .wdata ({coord_x, coord_y}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  pip_walk u_walk (
    .clk      (clk),
    .rst      (rst),
    .qry      (qry),
    .res_take (res_take),
    .stat     (stat),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  assign res_take = stat.res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      location <= stat.loc;
    end
  end

endmodule
